FILE: design/csd_pkg.sv
// Shared types, constants and helpers for the complement-aware set dedup block.
package csd_pkg;

  // Default sizing of the block
  localparam int unsigned MaxNodesDef = 256;
  localparam int unsigned MaxSetsDef  = 64;
  localparam int unsigned WordBitsDef = 32;

  // Fixed field widths
  localparam int unsigned CfgW  = 9;
  localparam int unsigned IdW   = 7;
  localparam int unsigned DiscW = 16;

  localparam logic [CfgW-1:0] NumNodesRst = 9'd256;

  // Transaction opcodes
  typedef enum logic {
    OP_FLAG   = 1'b0,
    OP_COMMIT = 1'b1
  } csd_op_e;

  // Input transaction
  typedef struct packed {
    logic opcode;
    logic node_in_set;
    logic last_node;
  } csd_in_t;

  // Result transaction
  typedef struct packed {
    logic             duplicate;
    logic             rejected_full;
    logic [IdW-1:0]   new_set_id;
    logic [IdW-1:0]   stored_sets;
    logic [DiscW-1:0] discarded_count;
  } csd_res_t;

  // Index width for a given depth, at least one bit
  function automatic int unsigned idx_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: design/csd_store.sv
// Set store: bitmap word memory and set size memory, registered reads.
module csd_store import csd_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef,
  parameter int unsigned Depth    = 512,
  parameter int unsigned Sets     = MaxSetsDef,
  parameter int unsigned SizeW    = 9,
  localparam int unsigned AW      = idx_w(Depth),
  localparam int unsigned SW      = idx_w(Sets)
) (
  input  logic                clk_i,
  input  logic                word_we_i,
  input  logic [AW-1:0]       word_waddr_i,
  input  logic [WordBits-1:0] word_wdata_i,
  input  logic [AW-1:0]       word_raddr_i,
  output logic [WordBits-1:0] word_rdata_o,
  input  logic                size_we_i,
  input  logic [SW-1:0]       size_waddr_i,
  input  logic [SizeW-1:0]    size_wdata_i,
  input  logic [SW-1:0]       size_raddr_i,
  output logic [SizeW-1:0]    size_rdata_o
);

  logic [WordBits-1:0] word_mem [Depth];
  logic [SizeW-1:0]    size_mem [Sets];
  logic [WordBits-1:0] word_rdata_q;
  logic [SizeW-1:0]    size_rdata_q;

  // Bitmap words: one write, one read port
  always_ff @(posedge clk_i) begin
    if (word_we_i) begin
      word_mem[word_waddr_i] <= word_wdata_i;
    end
    word_rdata_q <= word_mem[word_raddr_i];
  end

  // Set sizes
  always_ff @(posedge clk_i) begin
    if (size_we_i) begin
      size_mem[size_waddr_i] <= size_wdata_i;
    end
    size_rdata_q <= size_mem[size_raddr_i];
  end

  assign word_rdata_o = word_rdata_q;
  assign size_rdata_o = size_rdata_q;

endmodule

FILE: design/csd_match.sv
// Compare unit: one stored word against the candidate word or its masked complement.
module csd_match import csd_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef,
  parameter int unsigned Words    = 8,
  parameter int unsigned NodeW    = 9,
  localparam int unsigned WIW     = idx_w(Words)
) (
  input  logic [WIW-1:0]      word_idx_i,
  input  logic [NodeW-1:0]    eff_n_i,
  input  logic [WordBits-1:0] cand_word_i,
  input  logic [WordBits-1:0] st_word_i,
  input  logic [NodeW-1:0]    cand_size_i,
  input  logic [NodeW-1:0]    st_size_i,
  output logic                word_eq_o,
  output logic                size_eq_o
);

  localparam int unsigned LoW = $clog2(Words * WordBits + 1);
  localparam int unsigned CW  = ((LoW > NodeW) ? LoW : NodeW) + 1;

  logic [CW-1:0]       lo;
  logic [WordBits-1:0] mask;
  logic [WordBits-1:0] comp;
  logic [NodeW:0]      diff;

  // First node index held by this word
  assign lo = CW'(word_idx_i) * CW'(WordBits);

  // Valid-node mask for this word
  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      mask[b] = (lo + CW'(b)) < CW'(eff_n_i);
    end
  end

  assign comp      = ~cand_word_i & mask;
  assign word_eq_o = (st_word_i == cand_word_i) || (st_word_i == comp);

  // Size equals candidate or node count minus candidate (negative never matches)
  assign diff      = {1'b0, eff_n_i} - {1'b0, st_size_i};
  assign size_eq_o = (cand_size_i == st_size_i) || (diff == {1'b0, cand_size_i});

endmodule

FILE: design/complement_aware_set_dedup.sv
// Top level: candidate builder, scan/commit sequencer and result register.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+--------------------------------------
//  input    | start_i, busy_o, in_i          | taken when start_i && !busy_o
//  result   | done_o, res_o                  | one-cycle strobe, no backpressure
//  config   | cfg_we_i, cfg_wdata_i          | num_nodes written when cfg_we_i
//
//  A node flag without last_node keeps the block idle and gives no result.
//  A last flag holds busy_o through a scan of the store:
//  the scan streams every stored word through the single read port of the word memory.
//  A commit holds busy_o while it writes the candidate, one word write per cycle; a rejected
//  commit does not raise busy_o. Each result shows on done_o the cycle after it is decided.
//  Reset is asynchronous and clears control state; the store is not cleared,
//  since only entries below the set count are ever read.
module complement_aware_set_dedup import csd_pkg::*; #(
  parameter int unsigned MaxNodes = MaxNodesDef,
  parameter int unsigned MaxSets  = MaxSetsDef,
  parameter int unsigned WordBits = WordBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  csd_in_t         in_i,
  output logic            done_o,
  output csd_res_t        res_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned Wps   = (MaxNodes + WordBits - 1) / WordBits;
  localparam int unsigned Depth = MaxSets * Wps;
  localparam int unsigned NW    = $clog2(MaxNodes + 1);
  localparam int unsigned EW    = (NW > CfgW) ? NW : CfgW;
  localparam int unsigned SCW   = $clog2(MaxSets + 1);
  localparam int unsigned SIW   = idx_w(MaxSets);
  localparam int unsigned WIW   = idx_w(Wps);
  localparam int unsigned AW    = idx_w(Depth);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } csd_state_e;

  csd_state_e state_q, state_d;

  logic [CfgW-1:0]                nn_q;
  logic [Wps-1:0][WordBits-1:0]   cand_q, cand_d, cand_base;
  logic [NW-1:0]                  cand_size_q, cand_size_d, size_base;
  logic [NW-1:0]                  pos_q, pos_d;
  logic [SCW-1:0]                 set_count_q, set_count_d;
  logic [DiscW-1:0]               disc_q, disc_d;
  logic                           pending_q, pending_d;
  logic [SCW-1:0]                 rd_set_q, rd_set_d;
  logic [WIW-1:0]                 rd_word_q, rd_word_d;
  logic [AW-1:0]                  rd_addr_q, rd_addr_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [WIW-1:0]                 cmp_word_q, cmp_word_d;
  logic                           ok_q, ok_d;
  logic                           dup_q, dup_d;
  logic [WIW-1:0]                 wr_word_q, wr_word_d;
  logic [AW-1:0]                  base_q, base_d;
  logic                           done_q, done_d;
  csd_res_t                       res_q, res_d;

  logic [EW-1:0]       nn_ext;
  logic [NW-1:0]       eff_n;
  logic                accept;
  logic                hit;
  logic                issuing;
  logic                ok_now;
  logic [DiscW-1:0]    disc_inc;
  logic [WordBits-1:0] st_word;
  logic [NW-1:0]       st_size;
  logic                word_eq;
  logic                size_eq;
  logic                word_we;
  logic                size_we;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // Effective node count
  assign nn_ext = EW'(nn_q);
  assign eff_n  = (nn_ext > EW'(MaxNodes)) ? NW'(MaxNodes) : NW'(nn_ext);

  assign issuing  = (rd_set_q != set_count_q);
  assign disc_inc = (disc_q != '1) ? disc_q + DiscW'(1) : disc_q;
  assign word_we  = (state_q == ST_COMMIT);
  assign size_we  = word_we && (wr_word_q == '0);

  // Store
  csd_store #(
    .WordBits (WordBits),
    .Depth    (Depth),
    .Sets     (MaxSets),
    .SizeW    (NW)
  ) u_store (
    .clk_i        (clk_i),
    .word_we_i    (word_we),
    .word_waddr_i (AW'(base_q + AW'(wr_word_q))),
    .word_wdata_i (cand_q[wr_word_q]),
    .word_raddr_i (rd_addr_q),
    .word_rdata_o (st_word),
    .size_we_i    (size_we),
    .size_waddr_i (set_count_q[SIW-1:0]),
    .size_wdata_i (cand_size_q),
    .size_raddr_i (rd_set_q[SIW-1:0]),
    .size_rdata_o (st_size)
  );

  // Shared compare unit
  csd_match #(
    .WordBits (WordBits),
    .Words    (Wps),
    .NodeW    (NW)
  ) u_match (
    .word_idx_i  (cmp_word_q),
    .eff_n_i     (eff_n),
    .cand_word_i (cand_q[cmp_word_q]),
    .st_word_i   (st_word),
    .cand_size_i (cand_size_q),
    .st_size_i   (st_size),
    .word_eq_o   (word_eq),
    .size_eq_o   (size_eq)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    cand_size_d = cand_size_q;
    pos_d       = pos_q;
    set_count_d = set_count_q;
    disc_d      = disc_q;
    pending_d   = pending_q;
    rd_set_d    = rd_set_q;
    rd_word_d   = rd_word_q;
    rd_addr_d   = rd_addr_q;
    cmp_vld_d   = 1'b0;
    cmp_word_d  = cmp_word_q;
    ok_d        = ok_q;
    dup_d       = dup_q;
    wr_word_d   = wr_word_q;
    base_d      = base_q;
    done_d      = 1'b0;
    res_d       = res_q;
    cand_base   = cand_q;
    size_base   = cand_size_q;
    hit         = 1'b0;
    ok_now      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.opcode == OP_FLAG) begin
            // New set starts: clear candidate before applying the flag
            if (pos_q == '0) begin
              cand_base = '0;
              size_base = '0;
              pending_d = 1'b0;
            end
            hit    = in_i.node_in_set && (pos_q < eff_n);
            cand_d = cand_base;
            for (int w = 0; w < Wps; w++) begin
              for (int b = 0; b < WordBits; b++) begin
                if ((w * WordBits + b) < MaxNodes) begin
                  if (hit && (pos_q == NW'(w * WordBits + b))) begin
                    cand_d[w][b] = 1'b1;
                  end
                end
              end
            end
            cand_size_d = size_base + NW'(hit);
            pos_d       = (pos_q < NW'(MaxNodes)) ? pos_q + NW'(1) : pos_q;
            if (in_i.last_node) begin
              pos_d     = '0;
              rd_set_d  = '0;
              rd_word_d = '0;
              rd_addr_d = '0;
              dup_d     = 1'b0;
              ok_d      = 1'b0;
              state_d   = ST_SCAN;
            end
          end else begin
            pos_d     = '0;
            pending_d = 1'b0;
            if (!pending_q || (set_count_q >= SCW'(MaxSets))) begin
              done_d                = 1'b1;
              res_d.duplicate       = 1'b0;
              res_d.rejected_full   = 1'b1;
              res_d.new_set_id      = '0;
              res_d.stored_sets     = IdW'(set_count_q);
              res_d.discarded_count = disc_q;
            end else begin
              wr_word_d = '0;
              state_d   = ST_COMMIT;
            end
          end
        end
      end

      ST_SCAN: begin
        // Issue reads, one stored word per cycle
        if (issuing) begin
          cmp_vld_d  = 1'b1;
          cmp_word_d = rd_word_q;
          rd_addr_d  = rd_addr_q + AW'(1);
          if (rd_word_q == WIW'(Wps - 1)) begin
            rd_word_d = '0;
            rd_set_d  = rd_set_q + SCW'(1);
          end else begin
            rd_word_d = rd_word_q + WIW'(1);
          end
        end
        // Compare the word read last cycle
        if (cmp_vld_q) begin
          ok_now = ((cmp_word_q == '0) ? size_eq : ok_q) && word_eq;
          ok_d   = ok_now;
          if ((cmp_word_q == WIW'(Wps - 1)) && ok_now) begin
            dup_d = 1'b1;
          end
        end
        // Scan done
        if (!issuing && !cmp_vld_q) begin
          if (dup_q) begin
            disc_d = disc_inc;
          end
          pending_d             = !dup_q;
          done_d                = 1'b1;
          res_d.duplicate       = dup_q;
          res_d.rejected_full   = 1'b0;
          res_d.new_set_id      = '0;
          res_d.stored_sets     = IdW'(set_count_q);
          res_d.discarded_count = dup_q ? disc_inc : disc_q;
          state_d               = ST_IDLE;
        end
      end

      ST_COMMIT: begin
        // Copy candidate words into the store
        if (wr_word_q == WIW'(Wps - 1)) begin
          set_count_d           = set_count_q + SCW'(1);
          base_d                = base_q + AW'(Wps);
          done_d                = 1'b1;
          res_d.duplicate       = 1'b0;
          res_d.rejected_full   = 1'b0;
          res_d.new_set_id      = IdW'(set_count_q + SCW'(1));
          res_d.stored_sets     = IdW'(set_count_q + SCW'(1));
          res_d.discarded_count = disc_q;
          state_d               = ST_IDLE;
        end else begin
          wr_word_d = wr_word_q + WIW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and candidate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nn_q        <= NumNodesRst;
      cand_q      <= '0;
      cand_size_q <= '0;
      pos_q       <= '0;
      set_count_q <= '0;
      disc_q      <= '0;
      pending_q   <= 1'b0;
      rd_set_q    <= '0;
      rd_word_q   <= '0;
      rd_addr_q   <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_word_q  <= '0;
      ok_q        <= 1'b0;
      dup_q       <= 1'b0;
      wr_word_q   <= '0;
      base_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        nn_q <= cfg_wdata_i;
      end
      cand_q      <= cand_d;
      cand_size_q <= cand_size_d;
      pos_q       <= pos_d;
      set_count_q <= set_count_d;
      disc_q      <= disc_d;
      pending_q   <= pending_d;
      rd_set_q    <= rd_set_d;
      rd_word_q   <= rd_word_d;
      rd_addr_q   <= rd_addr_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_word_q  <= cmp_word_d;
      ok_q        <= ok_d;
      dup_q       <= dup_d;
      wr_word_q   <= wr_word_d;
      base_q      <= base_d;
      done_q      <= done_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: design/csd_checker.sv
// Port-level checker for the set dedup block, bound to the top level.
module csd_checker import csd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input csd_in_t  in_i,
  input logic     done_o,
  input csd_res_t res_o
);

  // A duplicate verdict never carries commit fields
  a_dup_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.duplicate |-> !res_o.rejected_full && (res_o.new_set_id == '0))
    else $error("duplicate result carries commit fields");

  // A rejected commit assigns no id
  a_rej_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.rejected_full |-> (res_o.new_set_id == '0))
    else $error("rejected commit assigned an id");

  // A new id is the new set count
  a_id_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.new_set_id != '0) |-> (res_o.new_set_id == res_o.stored_sets))
    else $error("new set id differs from stored set count");

  // A non-last flag transaction produces no result
  a_flag_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (in_i.opcode == OP_FLAG) && !in_i.last_node |=> !done_o)
    else $error("result after a non-last flag");

  // A duplicate always leaves a nonzero discard count
  a_disc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.duplicate |-> (res_o.discarded_count != '0))
    else $error("duplicate with zero discard count");

endmodule

bind complement_aware_set_dedup csd_checker u_csd_checker (.*);

FILE: test/csd_scoreboard.sv
// Scoreboard for the set dedup block: mirrors its state, predicts and checks every result.
module csd_scoreboard
  import csd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  csd_in_t         in_i,
  input  logic            done_i,
  input  csd_res_t        res_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output int              pending_o,
  output int              errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Nodes     = MaxNodesDef;
  localparam int unsigned Sets      = MaxSetsDef;
  localparam int unsigned WBits     = WordBitsDef;
  localparam int unsigned Words     = (Nodes + WBits - 1) / WBits;
  localparam int unsigned MapW      = Words * WBits;
  localparam int unsigned ReportMax = 10;

  // Mirror of the block state
  logic [MapW-1:0]  set_map [Sets];
  int unsigned      set_size [Sets];
  logic [MapW-1:0]  cand_map;
  int unsigned      cand_size;
  int unsigned      node_pos;
  int unsigned      set_total;
  int unsigned      discards;
  bit               cand_ready;
  logic [CfgW-1:0]  node_cfg;

  // Results still owed by the block, oldest first
  csd_res_t due_results[$];

  function automatic int unsigned active_nodes();
    return (node_cfg > Nodes) ? Nodes : int'(node_cfg);
  endfunction

  // Candidate (or its complement within the node count) already in the store?
  function automatic bit already_stored();
    int unsigned      n;
    logic [MapW-1:0]  valid;
    logic [WBits-1:0] cw;
    logic [WBits-1:0] sw;
    bit               word_ok;
    n = active_nodes();
    valid = '0;
    for (int i = 0; i < MapW; i++) begin
      if (i < n) valid[i] = 1'b1;
    end
    for (int s = 0; s < set_total && s < Sets; s++) begin
      if (cand_size != set_size[s] && int'(cand_size) != int'(n) - int'(set_size[s])) continue;
      word_ok = 1'b1;
      // decided word by word: each word may match plain or complemented
      for (int w = 0; w < Words; w++) begin
        cw = cand_map[w*WBits +: WBits];
        sw = set_map[s][w*WBits +: WBits];
        if (cw != sw && ((~cw) & valid[w*WBits +: WBits]) != sw) word_ok = 1'b0;
      end
      if (word_ok) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted transaction; tell whether it yields a result
  task automatic predict_dedup(input csd_in_t it, output bit produced, output csd_res_t r);
    bit dup;
    r = '0;
    produced = 1'b0;
    if (it.opcode == OP_FLAG) begin
      // first flag of a set starts a fresh candidate
      if (node_pos == 0) begin
        cand_map   = '0;
        cand_size  = 0;
        cand_ready = 1'b0;
      end
      if (node_pos < active_nodes() && it.node_in_set) begin
        cand_map[node_pos] = 1'b1;
        cand_size++;
      end
      if (node_pos < Nodes) node_pos++;
      if (!it.last_node) return;
      node_pos = 0;
      dup = already_stored();
      if (dup) begin
        if (discards < 16'hFFFF) discards++;
        cand_ready = 1'b0;
      end else begin
        cand_ready = 1'b1;
      end
      r.duplicate = dup;
    end else begin
      // commit: refused when nothing is pending or the store is full
      if (!cand_ready || set_total >= Sets) begin
        r.rejected_full = 1'b1;
      end else begin
        set_map[set_total]  = cand_map;
        set_size[set_total] = cand_size;
        set_total++;
        r.new_set_id = IdW'(set_total);
      end
      cand_ready = 1'b0;
      node_pos   = 0;
    end
    r.stored_sets     = IdW'(set_total);
    r.discarded_count = DiscW'(discards);
    produced = 1'b1;
  endtask

  task automatic flag_error(input string what, input csd_res_t want, input csd_res_t got);
    errors_o++;
    if (errors_o <= ReportMax)
      $display("%s at %0t: dup %b/%b rej %b/%b id %0d/%0d sets %0d/%0d disc %0d/%0d (exp/act)",
               what, $time, want.duplicate, got.duplicate, want.rejected_full,
               got.rejected_full, want.new_set_id, got.new_set_id, want.stored_sets,
               got.stored_sets, want.discarded_count, got.discarded_count);
  endtask

  // Monitor: results first, since a result never belongs to a transaction of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    csd_res_t want;
    csd_res_t fresh;
    bit       produced;
    if (!rst_ni) begin
      node_cfg   = NumNodesRst;
      cand_map   = '0;
      cand_size  = 0;
      node_pos   = 0;
      set_total  = 0;
      discards   = 0;
      cand_ready = 1'b0;
      due_results.delete();
      pending_o  = 0;
    end else begin
      if (done_i) begin
        if (due_results.size() == 0) begin
          want = 'x;
          flag_error("unexpected result", want, res_i);
        end else begin
          want = due_results.pop_front();
          if (res_i.duplicate !== want.duplicate ||
              res_i.rejected_full !== want.rejected_full ||
              res_i.new_set_id !== want.new_set_id ||
              res_i.stored_sets !== want.stored_sets ||
              res_i.discarded_count !== want.discarded_count)
            flag_error("result mismatch", want, res_i);
        end
      end
      if (cfg_we_i) node_cfg = cfg_wdata_i;
      if (start_i && !busy_i) begin
        predict_dedup(in_i, produced, fresh);
        if (produced) due_results.push_back(fresh);
      end
      pending_o = due_results.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the set dedup block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csd_pkg::*;

  localparam int unsigned MapW         = MaxNodesDef;
  localparam int unsigned ItemTarget   = 750;
  localparam int unsigned CommitTarget = 90;
  // worst case: ~1300 transactions, each a full 64-set scan plus the longest gap
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned TailCycles   = 64;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  csd_in_t         cmd       = '0;
  logic            done;
  csd_res_t        res;
  logic            cfg_we    = 1'b0;
  logic [CfgW-1:0] cfg_wdata = '0;

  int              pending;
  int              errors;
  int unsigned     cycles      = 0;
  int unsigned     items       = 0;
  int unsigned     set_commits = 0;
  bit              gaps_on     = 1'b1;
  logic [MapW-1:0] history[$];

  complement_aware_set_dedup uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .in_i        (cmd),
    .done_o      (done),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  csd_scoreboard u_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .in_i        (cmd),
    .done_i      (done),
    .res_i       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [MapW-1:0] valid_mask(input int unsigned n);
    logic [MapW-1:0] m;
    m = '0;
    for (int i = 0; i < MapW; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [MapW-1:0] random_map();
    logic [MapW-1:0] m;
    for (int k = 0; k < MapW / 32; k++) m[k*32 +: 32] = $urandom;
    return m;
  endfunction

  // One transaction: drive at the falling edge, hold until taken
  task automatic take(input csd_in_t c);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    items++;
  endtask

  // Sender gap; the command bus carries junk meanwhile
  task automatic hold_off(input int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    cmd   <= csd_in_t'(3'($urandom));
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 11));
  endtask

  task automatic flag(input bit member, input bit last);
    csd_in_t c;
    c.opcode      = OP_FLAG;
    c.node_in_set = member;
    c.last_node   = last;
    maybe_gap();
    take(c);
  endtask

  // Commit; the other fields are don't-care and get random values
  task automatic commit();
    csd_in_t c;
    c.opcode      = OP_COMMIT;
    c.node_in_set = 1'($urandom_range(0, 1));
    c.last_node   = 1'($urandom_range(0, 1));
    maybe_gap();
    take(c);
  endtask

  task automatic send_set(input logic [MapW-1:0] map, input int unsigned len);
    bit member;
    for (int unsigned i = 0; i < len; i++) begin
      member = (i < MapW) ? map[i] : 1'($urandom_range(0, 1));
      flag(member, i == len - 1);
    end
  endtask

  // Node count write, only once the block has gone quiet
  task automatic write_nodes(input int unsigned value);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CfgW'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= CfgW'($urandom);
  endtask

  initial begin
    int unsigned     phase;
    int unsigned     nodes;
    int unsigned     n_eff;
    int unsigned     len;
    int unsigned     cut;
    int unsigned     pick;
    bit              big;
    logic [MapW-1:0] map;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty commit, store, plain and complemented duplicates
    commit();
    write_nodes(4);
    send_set(MapW'(4'b0101), 4);
    commit();
    send_set(MapW'(4'b0101), 4);
    send_set(MapW'(4'b1010), 4);
    commit();
    // flags past the node count are dropped
    send_set(MapW'(6'b111100), 6);
    commit();
    // commit in the middle of a set
    flag(1'b1, 1'b0);
    flag(1'b0, 1'b0);
    commit();
    // zero nodes: empty candidate, empty complement
    write_nodes(0);
    flag(1'b1, 1'b1);

    // Random phases of well formed sets, reusing earlier maps to hit duplicates
    phase = 0;
    while (items < ItemTarget || set_commits < CommitTarget) begin
      phase++;
      gaps_on = !(items + 120 >= ItemTarget && set_commits + 10 >= CommitTarget) &&
                $urandom_range(0, 3) != 0;
      big  = (phase == 3);
      pick = $urandom_range(0, 99);
      if (big)            nodes = MaxNodesDef;
      else if (pick < 6)  nodes = 0;
      else if (pick < 10) nodes = 1;
      else if (pick < 16) nodes = $urandom_range(30, 34);
      else if (pick < 22) nodes = $urandom_range(MaxNodesDef + 1, (1 << CfgW) - 1);
      else                nodes = $urandom_range(2, 10);
      write_nodes(nodes);
      n_eff = (nodes > MapW) ? MapW : nodes;

      repeat (big ? 1 : $urandom_range(1, 5)) begin
        // length: usually the node count, sometimes short or overrunning
        pick = $urandom_range(0, 99);
        if (big)               len = MapW + 1;
        else if (nodes > MapW) len = $urandom_range(1, 12);
        else if (n_eff == 0)   len = $urandom_range(1, 3);
        else if (pick < 10)    len = $urandom_range(1, n_eff);
        else if (pick < 15)    len = n_eff + $urandom_range(1, 3);
        else                   len = n_eff;

        // contents: an earlier map or its complement, trivial maps, random
        pick = $urandom_range(0, 99);
        if (pick < 15 && history.size() > 0) begin
          map = history[$urandom_range(0, history.size() - 1)];
          if ($urandom_range(0, 1)) map = ~map & valid_mask(n_eff);
        end else if (pick < 18) begin
          map = '0;
        end else if (pick < 21) begin
          map = '1;
        end else begin
          map = random_map();
        end
        history.push_back(map & valid_mask((len < n_eff) ? len : n_eff));
        if (history.size() > 32) void'(history.pop_front());

        pick = $urandom_range(0, 99);
        if (pick < 5 && len > 1) begin
          // broken set: commit before the last flag
          cut = $urandom_range(1, len - 1);
          for (int unsigned i = 0; i < cut; i++) flag(map[i], 1'b0);
          commit();
        end else begin
          send_set(map, len);
          if (pick < 90) begin
            commit();
            set_commits++;
          end
          if (pick >= 96) commit();
        end
      end
    end

    // Drain and let any stray result show up
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
